// File: hw/rtl/umalu_pkg.sv
`timescale 1ns / 1ps

package umalu_pkg;

	localparam int DATA_W   = 32;
	localparam int NUM_REGS = 8;
	localparam int IDX_W    = $clog2(NUM_REGS);
	localparam int BYTE_W   = 8;
	localparam int IMM_W    = 25;
	localparam int CNT_W    = $clog2(DATA_W);

	// instruction word fields
	localparam int C_LSB  = 0;
	localparam int B_LSB  = 3;
	localparam int A_LSB  = 6;
	localparam int LI_LSB = 25;

	localparam logic [DATA_W-1:0] BYTE_MAX  = DATA_W'(255);
	localparam logic [CNT_W-1:0]  ITER_LAST = CNT_W'(DATA_W - 1);

	typedef enum logic [2:0] {
		MODE_CMOV  = 3'd0,
		MODE_ADD   = 3'd1,
		MODE_MUL   = 3'd2,
		MODE_DIV   = 3'd3,
		MODE_NAND  = 3'd4,
		MODE_OUT   = 3'd5,
		MODE_IN    = 3'd6,
		MODE_LOADI = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DIVZ  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		UOP_ADD = 2'd0,
		UOP_MUL = 2'd1,
		UOP_DIV = 2'd2
	} uop_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_ITER = 2'd2,
		S_FIN  = 2'd3
	} state_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx_b;
		logic [IDX_W-1:0] idx_c;
	} rf_rd_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] data;
	} rf_wr_t;

	typedef struct packed {
		logic start;
		uop_t op;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_stat_t;

endpackage

// File: hw/rtl/umalu_in_if.sv
`timescale 1ns / 1ps

interface umalu_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [31:0] instruction;
	logic [7:0]  in_byte;
	logic        in_eof;

	modport source (output valid, mode, instruction, in_byte, in_eof, input ready);
	modport sink   (input valid, mode, instruction, in_byte, in_eof, output ready);
endinterface

// File: hw/rtl/umalu_out_if.sv
`timescale 1ns / 1ps

interface umalu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic [1:0] status;

	modport source (output valid, out_byte, out_valid, status, input ready);
	modport sink   (input valid, out_byte, out_valid, status, output ready);
endinterface

// File: hw/rtl/umalu_regfile.sv
`timescale 1ns / 1ps

module umalu_regfile (
	input  logic                              clk,
	input  logic                              arst_n,
	input  umalu_pkg::rf_rd_t                 rd,
	input  umalu_pkg::rf_wr_t                 wr,
	output logic [umalu_pkg::DATA_W-1:0]      rdata_b,
	output logic [umalu_pkg::DATA_W-1:0]      rdata_c
);

	logic [umalu_pkg::DATA_W-1:0]   mem [umalu_pkg::NUM_REGS];
	logic [umalu_pkg::NUM_REGS-1:0] valid_q;
	logic [umalu_pkg::DATA_W-1:0]   rd_b_q, rd_c_q;
	logic                           rv_b_q, rv_c_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd.en) begin
			rd_b_q <= mem[rd.idx_b];
			rd_c_q <= mem[rd.idx_c];
		end
	end

	// entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_b_q  <= 1'b0;
			rv_c_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (rd.en) begin
				rv_b_q <= valid_q[rd.idx_b];
				rv_c_q <= valid_q[rd.idx_c];
			end
		end
	end

	assign rdata_b = rv_b_q ? rd_b_q : '0;
	assign rdata_c = rv_c_q ? rd_c_q : '0;

	a_wr_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> valid_q[$past(wr.idx)])
		else $error("written register not marked valid");

endmodule

// File: hw/rtl/umalu_iter.sv
`timescale 1ns / 1ps

module umalu_iter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  umalu_pkg::alu_ctl_t               ctl,
	input  logic [umalu_pkg::DATA_W-1:0]      opb,
	input  logic [umalu_pkg::DATA_W-1:0]      opc,
	output umalu_pkg::alu_stat_t              stat,
	output logic [umalu_pkg::DATA_W-1:0]      result
);

	localparam int DW = umalu_pkg::DATA_W;

	logic [DW-1:0]                  a_q, b_q, c_q;
	umalu_pkg::uop_t                op_q;
	logic                           busy_q;
	logic [umalu_pkg::CNT_W-1:0]    cnt_q;

	logic [DW:0]   x, y;
	logic          sub;
	logic [DW+1:0] sum;
	logic          ge;

	// shared adder: accumulate for add/mul, trial subtract for divide
	always_comb begin
		case (op_q)
			umalu_pkg::UOP_DIV: begin
				x   = {a_q, b_q[DW-1]};
				y   = {1'b0, c_q};
				sub = 1'b1;
			end
			default: begin
				x   = {1'b0, a_q};
				y   = c_q[0] ? {1'b0, b_q} : '0;
				sub = 1'b0;
			end
		endcase
		sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{(DW+1){1'b0}}, sub};
		ge  = sum[DW+1];
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q <= ctl.op;
			b_q  <= opb;
			case (ctl.op)
				umalu_pkg::UOP_ADD: begin
					a_q <= opc;
					c_q <= DW'(1);
				end
				default: begin
					a_q <= '0;
					c_q <= opc;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				umalu_pkg::UOP_DIV: begin
					a_q <= ge ? sum[DW-1:0] : x[DW-1:0];
					b_q <= {b_q[DW-2:0], ge};
				end
				default: begin
					a_q <= sum[DW-1:0];
					b_q <= b_q << 1;
					c_q <= c_q >> 1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= (ctl.op == umalu_pkg::UOP_ADD) ? '0 : umalu_pkg::ITER_LAST;
		end else if (busy_q) begin
			busy_q <= (cnt_q != '0);
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);
	assign result    = (op_q == umalu_pkg::UOP_DIV) ? b_q : a_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> busy_q)
		else $error("unit not busy after start");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && !ctl.start) |=> !busy_q)
		else $error("unit still busy after last step");

endmodule

// File: hw/rtl/um_register_alu_execute.sv
`timescale 1ns / 1ps

// Register execute unit of a 32-bit universal machine: eight 32-bit registers
// (zero after reset) and one operation per cmd transfer, chosen by mode:
// cmov, add, mul, unsigned div, nand, output, input and load immediate.
// Register fields are C = instruction[2:0], B = [5:3], A = [8:6]; load
// immediate writes instruction[24:0] to the register at [27:25]. Every
// command gives exactly one res transfer with out_byte/out_valid/status.
// A zero divisor (status 1) or an output value above 255 (status 2) leaves
// the registers untouched. One command is in flight at a time: cmov, nand,
// output, input and load immediate go through the execute and final states;
// add, mul and div also pass the iterate state, and all three run on one
// shared 34-bit adder that steps once per cycle, 32 steps for mul (shift and
// add) and div (restoring); that adder sets the worst case. A finished
// result sits in an output register, so the next command is taken while the
// previous result waits; a full output register holds the sequencer in its
// final state.
module um_register_alu_execute (
	input  logic        clk,
	input  logic        arst_n,
	umalu_in_if.sink    cmd,
	umalu_out_if.source res
);

	localparam int DW = umalu_pkg::DATA_W;
	localparam int IW = umalu_pkg::IDX_W;

	umalu_pkg::state_t state_q, state_d;

	// latched command
	logic [2:0]                    mode_q;
	logic [DW-1:0]                 ins_q;
	logic [umalu_pkg::BYTE_W-1:0]  inb_q;
	logic                          eof_q;
	umalu_pkg::mode_t              mode;

	// pending result
	logic                          wr_en_q, use_unit_q;
	logic [IW-1:0]                 wr_idx_q;
	logic [DW-1:0]                 wr_data_q;
	logic [umalu_pkg::BYTE_W-1:0]  ob_q;
	logic                          ov_q;
	umalu_pkg::status_t            st_q;

	// output register
	logic                          out_full_q;
	logic [umalu_pkg::BYTE_W-1:0]  out_byte_q;
	logic                          out_valid_q;
	logic [1:0]                    status_q;

	logic [DW-1:0]                 vb, vc, unit_res;
	umalu_pkg::rf_rd_t             rf_rd;
	umalu_pkg::rf_wr_t             rf_wr;
	umalu_pkg::alu_ctl_t           alu_ctl;
	umalu_pkg::alu_stat_t          alu_stat;

	// decode of the execute cycle
	logic                          e_wr_en, e_use_unit;
	logic [IW-1:0]                 e_wr_idx;
	logic [DW-1:0]                 e_wr_data;
	logic [umalu_pkg::BYTE_W-1:0]  e_ob;
	logic                          e_ov;
	umalu_pkg::status_t            e_st;
	logic                          e_start;
	umalu_pkg::uop_t               e_op;

	logic                          cmd_xfer, out_load;

	assign mode     = umalu_pkg::mode_t'(mode_q);
	assign cmd_xfer = cmd.valid && cmd.ready;

	umalu_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rf_rd),
		.wr      (rf_wr),
		.rdata_b (vb),
		.rdata_c (vc)
	);

	umalu_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.opb    (vb),
		.opc    (vc),
		.stat   (alu_stat),
		.result (unit_res)
	);

	// operand read is issued straight from the command on its transfer
	assign rf_rd.en    = cmd_xfer;
	assign rf_rd.idx_b = cmd.instruction[umalu_pkg::B_LSB +: IW];
	assign rf_rd.idx_c = cmd.instruction[umalu_pkg::C_LSB +: IW];

	always_comb begin
		e_wr_en    = 1'b0;
		e_use_unit = 1'b0;
		e_wr_idx   = ins_q[umalu_pkg::A_LSB +: IW];
		e_wr_data  = vb;
		e_ob       = '0;
		e_ov       = 1'b0;
		e_st       = umalu_pkg::ST_OK;
		e_start    = 1'b0;
		e_op       = umalu_pkg::UOP_ADD;
		case (mode)
			umalu_pkg::MODE_CMOV: begin
				e_wr_en = (vc != '0);
			end
			umalu_pkg::MODE_ADD: begin
				e_wr_en    = 1'b1;
				e_use_unit = 1'b1;
				e_start    = 1'b1;
			end
			umalu_pkg::MODE_MUL: begin
				e_wr_en    = 1'b1;
				e_use_unit = 1'b1;
				e_start    = 1'b1;
				e_op       = umalu_pkg::UOP_MUL;
			end
			umalu_pkg::MODE_DIV: begin
				if (vc == '0) begin
					e_st = umalu_pkg::ST_DIVZ;
				end else begin
					e_wr_en    = 1'b1;
					e_use_unit = 1'b1;
					e_start    = 1'b1;
					e_op       = umalu_pkg::UOP_DIV;
				end
			end
			umalu_pkg::MODE_NAND: begin
				e_wr_en   = 1'b1;
				e_wr_data = ~(vb & vc);
			end
			umalu_pkg::MODE_OUT: begin
				if (vc > umalu_pkg::BYTE_MAX) begin
					e_st = umalu_pkg::ST_RANGE;
				end else begin
					e_ob = vc[umalu_pkg::BYTE_W-1:0];
					e_ov = 1'b1;
				end
			end
			umalu_pkg::MODE_IN: begin
				e_wr_en   = 1'b1;
				e_wr_idx  = ins_q[umalu_pkg::C_LSB +: IW];
				e_wr_data = eof_q ? '1 : DW'(inb_q);
			end
			umalu_pkg::MODE_LOADI: begin
				e_wr_en   = 1'b1;
				e_wr_idx  = ins_q[umalu_pkg::LI_LSB +: IW];
				e_wr_data = DW'(ins_q[umalu_pkg::IMM_W-1:0]);
			end
			default: begin
				e_wr_en = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			umalu_pkg::S_IDLE: begin
				if (cmd_xfer) begin
					state_d = umalu_pkg::S_EXEC;
				end
			end
			umalu_pkg::S_EXEC: begin
				state_d = e_start ? umalu_pkg::S_ITER : umalu_pkg::S_FIN;
			end
			umalu_pkg::S_ITER: begin
				if (alu_stat.done) begin
					state_d = umalu_pkg::S_FIN;
				end
			end
			umalu_pkg::S_FIN: begin
				if (out_load) begin
					state_d = umalu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = umalu_pkg::S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd.ready     = 1'b0;
		alu_ctl.start = 1'b0;
		alu_ctl.op    = e_op;
		rf_wr.en      = 1'b0;
		rf_wr.idx     = wr_idx_q;
		rf_wr.data    = use_unit_q ? unit_res : wr_data_q;
		out_load      = 1'b0;
		case (state_q)
			umalu_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
			end
			umalu_pkg::S_EXEC: begin
				alu_ctl.start = e_start;
			end
			umalu_pkg::S_FIN: begin
				// rewrite while stalled is harmless: same index and data
				rf_wr.en = wr_en_q;
				out_load = !out_full_q || res.ready;
			end
			default: begin
				cmd.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= umalu_pkg::S_IDLE;
			wr_en_q    <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == umalu_pkg::S_EXEC) begin
				wr_en_q <= e_wr_en;
			end
			if (out_load) begin
				out_full_q <= 1'b1;
			end else if (res.ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			mode_q <= cmd.mode;
			ins_q  <= cmd.instruction;
			inb_q  <= cmd.in_byte;
			eof_q  <= cmd.in_eof;
		end
		if (state_q == umalu_pkg::S_EXEC) begin
			use_unit_q <= e_use_unit;
			wr_idx_q   <= e_wr_idx;
			wr_data_q  <= e_wr_data;
			ob_q       <= e_ob;
			ov_q       <= e_ov;
			st_q       <= e_st;
		end
		if (out_load) begin
			out_byte_q  <= ob_q;
			out_valid_q <= ov_q;
			status_q    <= st_q;
		end
	end

	assign res.valid     = out_full_q;
	assign res.out_byte  = out_byte_q;
	assign res.out_valid = out_valid_q;
	assign res.status    = status_q;

	a_xfer_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |=> (state_q == umalu_pkg::S_EXEC))
		else $error("command transfer did not enter execute");

	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == umalu_pkg::S_FIN && st_q != umalu_pkg::ST_OK) |-> !rf_wr.en)
		else $error("register write on an error status");

	a_unit_in_iter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == umalu_pkg::S_ITER) |-> alu_stat.busy)
		else $error("waiting on an idle arithmetic unit");

endmodule
